/* src/mvs_pkg.sv */
// ----------------------------------------------------------------------------
// mvs_pkg
// Shared widths, codes, types and the bucket index fold of the
// majority-vote sketch.
// ----------------------------------------------------------------------------
package mvs_pkg;

   // fixed field widths
   localparam int BUCKET_W = 12;
   localparam int FKEY_W   = 64;
   localparam int CNT_W    = 32;
   localparam int MAX_ROWS = 4;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;
   localparam int unsigned BUCKET_MAX = (1 << BUCKET_W) - 1;

   // parameter defaults
   localparam int DEF_ROWS     = 4;
   localparam int DEF_COLS     = 4096;
   localparam int DEF_KEY_BITS = 64;

   // transaction opcodes
   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_QUERY  = 1'b1
   } op_type;

   // per-row control from the top level
   typedef struct packed {
      logic                rd_en;
      logic [BUCKET_W-1:0] rd_bucket;
      logic                wr_en;
      logic                clr_en;
   } row_ctl_type;

   // reduce a bucket index modulo cols by conditional subtraction
   function automatic logic [BUCKET_W-1:0] mvs_fold(input logic [BUCKET_W-1:0] idx,
                                                    input int unsigned cols);
      logic [BUCKET_W-1:0] rem;
      int unsigned         step;
      rem = idx;
      for (int k = BUCKET_W - 1; k >= 0; k--) begin
         step = cols << k;
         if (step <= BUCKET_MAX && 32'(rem) >= step) begin
            rem = rem - BUCKET_W'(step);
         end
      end
      return rem;
   endfunction

endpackage

/* src/mvs_if.sv */
// ----------------------------------------------------------------------------
// mvs_if
// Valid/ready channels of the sketch: request and response.
// ----------------------------------------------------------------------------
interface mvs_req_if import mvs_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                opcode;
   logic [FKEY_W-1:0]   flow_key;
   logic [BUCKET_W-1:0] row0_bucket;
   logic [BUCKET_W-1:0] row1_bucket;
   logic [BUCKET_W-1:0] row2_bucket;
   logic [BUCKET_W-1:0] row3_bucket;

   modport source (output valid, opcode, flow_key, row0_bucket, row1_bucket,
                   row2_bucket, row3_bucket, input ready);
   modport sink   (input valid, opcode, flow_key, row0_bucket, row1_bucket,
                   row2_bucket, row3_bucket, output ready);
endinterface

interface mvs_rsp_if import mvs_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CNT_W-1:0] frequency_estimate;

   modport source (output valid, frequency_estimate, input ready);
   modport sink   (input valid, frequency_estimate, output ready);
endinterface

/* src/mvs_row.sv */
// ----------------------------------------------------------------------------
// mvs_row
// One sketch row: bucket memory with registered read, bypass of the
// previous write, majority-vote update and the row estimate.
// ----------------------------------------------------------------------------
module mvs_row import mvs_pkg::*; #(
   parameter int COLS     = DEF_COLS,
   parameter int KEY_BITS = DEF_KEY_BITS,
   parameter int COL_W    = $clog2(COLS)
) (
   input  logic                clock,
   input  logic                reset,
   input  row_ctl_type         ctl,
   input  logic [KEY_BITS-1:0] key,
   input  logic [COL_W-1:0]    clr_addr,
   output logic [CNT_W-1:0]    estimate
);

   typedef struct packed {
      logic                vld;
      logic [CNT_W-1:0]    total;
      logic [CNT_W-1:0]    ind;
      logic [KEY_BITS-1:0] key;
   } entry_type;

   entry_type          mem [COLS];
   entry_type          rd_data_ff;
   entry_type          fwd_data_ff;
   logic               fresh_ff;
   logic [COL_W-1:0]   b_addr_ff;
   logic [COL_W-1:0]   rd_addr;
   entry_type          cur;
   entry_type          nxt;
   logic               match;
   logic [CNT_W:0]     sum;
   logic [CNT_W-1:0]   diff;

   assign rd_addr = COL_W'(mvs_fold(ctl.rd_bucket, COLS));

   // bucket memory: clear sweep or write-back, one registered read
   always_ff @(posedge clock) begin
      if (ctl.clr_en) begin
         mem[clr_addr] <= '0;
      end else if (ctl.wr_en) begin
         mem[b_addr_ff] <= nxt;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
         b_addr_ff  <= rd_addr;
      end
   end

   // bypass when the read meets a write-back of the same bucket
   always_ff @(posedge clock) begin
      if (reset) begin
         fresh_ff <= 1'b0;
      end else if (ctl.rd_en) begin
         fresh_ff <= ctl.wr_en && (b_addr_ff == rd_addr);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         fwd_data_ff <= nxt;
      end
   end

   assign cur   = fresh_ff ? fwd_data_ff : rd_data_ff;
   assign match = cur.vld && (cur.key == key);

   // majority-vote update
   always_comb begin
      nxt       = cur;
      nxt.total = (cur.total == CNT_MAX) ? cur.total : cur.total + CNT_W'(1);
      if (match) begin
         nxt.ind = (cur.ind == CNT_MAX) ? cur.ind : cur.ind + CNT_W'(1);
      end else if (!cur.vld || cur.ind == '0) begin
         nxt.vld = 1'b1;
         nxt.key = key;
         nxt.ind = CNT_W'(1);
      end else begin
         nxt.ind = cur.ind - CNT_W'(1);
      end
   end

   // row estimate, halved
   assign sum  = {1'b0, cur.total} + {1'b0, cur.ind};
   assign diff = cur.total - cur.ind;

   always_comb begin
      if (match) begin
         estimate = sum[CNT_W:1];
      end else if (cur.total > cur.ind) begin
         estimate = {1'b0, diff[CNT_W-1:1]};
      end else begin
         estimate = '0;
      end
   end

endmodule

/* src/majority_vote_sketch_unit.sv */
// ----------------------------------------------------------------------------
// majority_vote_sketch_unit
// Heavy-flow sketch of ROWS rows by COLS buckets with majority-vote
// candidates; insert and frequency query over valid/ready channels.
// ----------------------------------------------------------------------------
// Takes one transaction per cycle sustained while the response channel keeps
// up; a response passes from acceptance through the memory read at the
// accepting edge, then bucket update and row estimates, then minimum over rows
// into the output register, and any stage may hold while a later one is full.
// Each row is one memory with a registered read port and a write port; an
// insert reads, updates and writes back its bucket, and an insert that hits
// the bucket just written by the previous insert takes the written value from
// a bypass register. After reset the block clears all rows in parallel, one
// bucket per cycle, and accepts no request until then. Bucket indices at or
// above COLS are reduced modulo COLS; only the low KEY_BITS key bits count.
// ----------------------------------------------------------------------------
module majority_vote_sketch_unit import mvs_pkg::*; #(
   parameter int ROWS     = DEF_ROWS,
   parameter int COLS     = DEF_COLS,
   parameter int KEY_BITS = DEF_KEY_BITS
) (
   input  logic      clock,
   input  logic      reset,
   mvs_req_if.sink   req_ch,
   mvs_rsp_if.source rsp_ch
);

   localparam int COL_W = $clog2(COLS);

   logic                clearing_ff;
   logic [COL_W-1:0]    clr_cnt_ff;
   logic                b_valid_ff;
   op_type              b_op_ff;
   logic [KEY_BITS-1:0] b_key_ff;
   logic                c_valid_ff;
   op_type              c_op_ff;
   logic [CNT_W-1:0]    c_est_ff [ROWS];
   logic                rsp_valid_ff;
   logic [CNT_W-1:0]    rsp_est_ff;
   logic [CNT_W-1:0]    rsp_est_in;
   logic [CNT_W-1:0]    row_est [ROWS];
   logic [BUCKET_W-1:0] bucket [MAX_ROWS];
   row_ctl_type         row_ctl [ROWS];
   logic                accept;
   logic                b_adv;
   logic                c_adv;
   logic                out_free;

   // stage handshakes
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign c_adv    = c_valid_ff && out_free;
   assign b_adv    = b_valid_ff && (!c_valid_ff || c_adv);
   assign accept   = req_ch.valid && req_ch.ready;

   assign req_ch.ready = !clearing_ff && (!b_valid_ff || b_adv);

   // clear sweep after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else if (clearing_ff) begin
         clr_cnt_ff <= clr_cnt_ff + COL_W'(1);
         if (clr_cnt_ff == COL_W'(COLS - 1)) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   assign bucket[0] = req_ch.row0_bucket;
   assign bucket[1] = req_ch.row1_bucket;
   assign bucket[2] = req_ch.row2_bucket;
   assign bucket[3] = req_ch.row3_bucket;

   // rows
   for (genvar r = 0; r < ROWS; r++) begin : g_row
      assign row_ctl[r].rd_en     = accept;
      assign row_ctl[r].rd_bucket = bucket[r];
      assign row_ctl[r].wr_en     = b_adv && (b_op_ff == OP_INSERT);
      assign row_ctl[r].clr_en    = clearing_ff;

      mvs_row #(
         .COLS     (COLS),
         .KEY_BITS (KEY_BITS),
         .COL_W    (COL_W)
      ) u_row (
         .clock    (clock),
         .reset    (reset),
         .ctl      (row_ctl[r]),
         .key      (b_key_ff),
         .clr_addr (clr_cnt_ff),
         .estimate (row_est[r])
      );
   end

   // update stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (accept) begin
         b_valid_ff <= 1'b1;
      end else if (b_adv) begin
         b_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_op_ff  <= op_type'(req_ch.opcode);
         b_key_ff <= req_ch.flow_key[KEY_BITS-1:0];
      end
   end

   // estimate stage
   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (b_adv) begin
         c_valid_ff <= 1'b1;
      end else if (c_adv) begin
         c_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (b_adv) begin
         c_op_ff  <= b_op_ff;
         c_est_ff <= row_est;
      end
   end

   // minimum over rows, zero for insert
   always_comb begin
      rsp_est_in = CNT_MAX;
      for (int r = 0; r < ROWS; r++) begin
         if (c_est_ff[r] < rsp_est_in) begin
            rsp_est_in = c_est_ff[r];
         end
      end
      if (c_op_ff == OP_INSERT) begin
         rsp_est_in = '0;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (c_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (c_adv) begin
         rsp_est_ff <= rsp_est_in;
      end
   end

   assign rsp_ch.valid              = rsp_valid_ff;
   assign rsp_ch.frequency_estimate = rsp_est_ff;

   // no transaction in flight while the clear sweep runs
   a_clear_idle: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> (!b_valid_ff && !c_valid_ff && !rsp_valid_ff))
      else $error("transaction in flight during clear sweep");

   // an accepted transaction reaches the update stage next cycle
   a_accept_b: assert property (@(posedge clock) disable iff (reset)
      accept |=> b_valid_ff)
      else $error("accepted transaction lost before update stage");

   // insert responses carry a zero estimate
   a_insert_zero: assert property (@(posedge clock) disable iff (reset)
      (c_adv && c_op_ff == OP_INSERT) |=> (rsp_valid_ff && rsp_est_ff == '0))
      else $error("insert response with nonzero estimate");

   // a stalled update stage keeps its item until the estimate stage frees
   a_b_hold: assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && !b_adv) |=> (b_valid_ff && $stable(b_key_ff)))
      else $error("update stage item dropped while stalled");

endmodule
